[hdl/sdpq_pkg.sv]
package sdpq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_BITS  = 32;
    localparam int STORE_BITS = (DATA_BITS < 32) ? DATA_BITS : 32;
    localparam int PRI_BITS   = 32;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS = STORE_BITS + PRI_BITS;

    typedef logic [IDX_BITS-1:0]          t_idx;
    typedef logic [CNT_BITS-1:0]          t_cnt;
    typedef logic [STORE_BITS-1:0]        t_sdata;
    typedef logic signed [PRI_BITS-1:0]   t_pri;

    typedef struct packed {
        t_sdata data;
        t_pri   pri;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_EXT_LO = 2'd1,
        CMD_EXT_HI = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_LO,
        S_INS_HI,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EXT_RD,
        S_EXT_WAIT,
        S_DONE
    } t_state;

endpackage

[hdl/sdpq_ram.sv]
module sdpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sorted_double_ended_priority_queue_top.sv]
// Sorted double-ended priority queue holding up to DEPTH entries of data and
// signed priority in ascending priority order, kept in a circular buffer in RAM.
// The input channel (i_in_valid, o_in_stall) carries a command with an item;
// a transfer happens on a rising edge with valid high and stall low.
// The output channel (o_out_valid, i_out_stall) returns exactly one result per
// command: a status, the removed entry, the current extremes and the count.
// The block works on one command at a time and stalls its input meanwhile.
// An insert at either end writes the item at the new end; an insert into the
// middle scans down from the highest entry, and every entry whose priority is
// not below the item's moves up one place. The scan is set by the single RAM
// read port with its registered read and by the one shared priority comparator:
// each stored entry is read in S_SCAN_RD, then compared and moved in S_SCAN_CMP.
// The result sits in an output register, so a new command is taken while a
// result still waits; if the receiver stalls and a second result is ready,
// the block holds it and keeps the input stalled until the first is taken.
// Reset empties the queue and drops any pending result; stored entries are
// not cleared, as only entries below the count are ever used.
module sorted_double_ended_priority_queue_top
    import sdpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_item_data,
    input  logic signed [31:0] i_item_priority,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_taken_data,
    output logic signed [31:0] o_taken_priority,
    output logic signed [31:0] o_lowest_data,
    output logic signed [31:0] o_lowest_priority,
    output logic signed [31:0] o_highest_data,
    output logic signed [31:0] o_highest_priority,
    output logic [4:0]         o_entry_count
);

    function automatic t_idx phys(t_idx head, t_idx ofs);
        logic [IDX_BITS:0] sum;
        sum = {1'b0, head} + {1'b0, ofs};
        if (sum >= (IDX_BITS + 1)'(DEPTH)) begin
            sum = sum - (IDX_BITS + 1)'(DEPTH);
        end
        return sum[IDX_BITS-1:0];
    endfunction

    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    t_entry  r_item, n_item;
    t_entry  r_lo, n_lo;
    t_entry  r_hi, n_hi;
    t_entry  r_taken, n_taken;
    t_status r_status, n_status;
    t_idx    r_head, n_head;
    t_idx    r_idx, n_idx;
    t_cnt    r_count, n_count;

    logic    r_ov, n_ov;
    t_status r_o_status;
    t_entry  r_o_taken, r_o_lo, r_o_hi;
    t_cnt    r_o_count;

    logic    in_xfer;
    logic    out_load;
    t_pri    cmp_a;
    logic    cmp_lt, cmp_eq;

    logic    ram_we;
    t_idx    ram_waddr, ram_raddr;
    t_entry  ram_wdata, rd;
    logic [ENTRY_BITS-1:0] ram_rdata;

    sdpq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd       = ram_rdata;
    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_ov || !i_out_stall);

    // One comparator serves the end checks and the scan.
    always_comb begin
        unique case (r_state)
            S_INS_LO: cmp_a = r_lo.pri;
            S_INS_HI: cmp_a = r_hi.pri;
            default:  cmp_a = rd.pri;
        endcase
    end

    assign cmp_lt = cmp_a < r_item.pri;
    assign cmp_eq = cmp_a == r_item.pri;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_INSERT:             n_state = S_INS_LO;
                        CMD_EXT_LO, CMD_EXT_HI: n_state = S_EXT_RD;
                        CMD_NONE:               n_state = S_DONE;
                    endcase
                end
            end
            S_INS_LO: begin
                if (r_count == CNT_BITS'(DEPTH) || r_count == '0 || !cmp_lt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS_HI;
                end
            end
            S_INS_HI: begin
                n_state = (cmp_lt || cmp_eq) ? S_DONE : S_SCAN_RD;
            end
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: n_state = cmp_lt ? S_DONE : S_SCAN_RD;
            S_EXT_RD:   n_state = (r_count <= CNT_BITS'(1)) ? S_DONE : S_EXT_WAIT;
            S_EXT_WAIT: n_state = S_DONE;
            S_DONE:     n_state = out_load ? S_IDLE : S_DONE;
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_item    = r_item;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_taken   = r_taken;
        n_status  = r_status;
        n_head    = r_head;
        n_idx     = r_idx;
        n_count   = r_count;
        ram_we    = 1'b0;
        ram_waddr = r_head;
        ram_wdata = r_item;
        ram_raddr = phys(r_head, r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd       = t_cmd'(i_cmd);
                    n_item.data = t_sdata'(i_item_data);
                    n_item.pri  = i_item_priority;
                    n_status    = ST_OK;
                    n_taken     = '0;
                end
            end
            S_INS_LO: begin
                if (r_count == CNT_BITS'(DEPTH)) begin
                    n_status = ST_FULL;
                end else if (r_count == '0) begin
                    ram_we  = 1'b1;
                    n_lo    = r_item;
                    n_hi    = r_item;
                    n_count = CNT_BITS'(1);
                end else if (!cmp_lt) begin
                    n_head    = phys(r_head, t_idx'(DEPTH - 1));
                    ram_we    = 1'b1;
                    ram_waddr = phys(r_head, t_idx'(DEPTH - 1));
                    n_lo      = r_item;
                    n_count   = r_count + CNT_BITS'(1);
                end
            end
            S_INS_HI: begin
                if (cmp_lt || cmp_eq) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(r_head, t_idx'(r_count));
                    n_hi      = r_item;
                    n_count   = r_count + CNT_BITS'(1);
                end else begin
                    n_idx = t_idx'(r_count - CNT_BITS'(1));
                end
            end
            S_SCAN_RD: begin
                ram_raddr = phys(r_head, r_idx);
            end
            S_SCAN_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_idx + t_idx'(1));
                if (cmp_lt) begin
                    ram_wdata = r_item;
                    n_count   = r_count + CNT_BITS'(1);
                end else begin
                    ram_wdata = rd;
                    n_idx     = r_idx - t_idx'(1);
                end
            end
            S_EXT_RD: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_taken = (r_cmd == CMD_EXT_LO) ? r_lo : r_hi;
                    n_count = r_count - CNT_BITS'(1);
                    if (r_cmd == CMD_EXT_LO) begin
                        ram_raddr = phys(r_head, t_idx'(1));
                        if (r_count > CNT_BITS'(1)) begin
                            n_head = phys(r_head, t_idx'(1));
                        end
                    end else begin
                        ram_raddr = phys(r_head, t_idx'(r_count - CNT_BITS'(2)));
                    end
                end
            end
            S_EXT_WAIT: begin
                if (r_cmd == CMD_EXT_LO) begin
                    n_lo = rd;
                end else begin
                    n_hi = rd;
                end
            end
            S_DONE: begin
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_ov = 1'b1;
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_item   <= n_item;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_taken  <= n_taken;
        r_status <= n_status;
        r_idx    <= n_idx;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_taken  <= r_taken;
            r_o_lo     <= (r_count == '0) ? '0 : r_lo;
            r_o_hi     <= (r_count == '0) ? '0 : r_hi;
            r_o_count  <= r_count;
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_ov;
    assign o_status           = r_o_status;
    assign o_taken_data       = 32'(r_o_taken.data);
    assign o_taken_priority   = r_o_taken.pri;
    assign o_lowest_data      = 32'(r_o_lo.data);
    assign o_lowest_priority  = r_o_lo.pri;
    assign o_highest_data     = 32'(r_o_hi.data);
    assign o_highest_priority = r_o_hi.pri;
    assign o_entry_count      = 5'(r_o_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("entry count exceeds depth");

    a_scan_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CMP && !cmp_lt) |-> (r_idx != '0))
        else $error("scan moved past the lowest entry");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_cmd == CMD_INSERT && r_count == CNT_BITS'(DEPTH))
        |=> ##1 (r_count == $past(r_count, 2)))
        else $error("insert into full queue changed the count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_entry_count == '0)
        |-> (o_lowest_priority == '0 && o_highest_priority == '0))
        else $error("empty queue reports nonzero extremes");

endmodule

[tb/sorted_double_ended_priority_queue_top_tb.sv]
module sorted_double_ended_priority_queue_top_tb;
    import sdpq_pkg::*;

    localparam int                 CLOCK_HALF   = 6;
    localparam int                 RESET_CYCLES = 11;
    localparam int                 IDLE_PCT     = 27;
    localparam int                 HOLD_CYCLES  = 300;
    localparam int                 DRAIN_CYCLES = 60;
    localparam int                 CYCLE_LIMIT  = 500000;
    localparam logic [31:0]        DATA_MASK    = 32'hFFFF_FFFF >> (32 - STORE_BITS);
    localparam logic signed [31:0] PRI_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] PRI_MAX      = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] taken_data;
        logic [31:0] taken_pri;
        logic [31:0] low_data;
        logic [31:0] low_pri;
        logic [31:0] high_data;
        logic [31:0] high_pri;
        logic [4:0]  count;
    } t_outcome;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_cmd;
    logic signed [31:0] i_item_data;
    logic signed [31:0] i_item_priority;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_taken_data;
    logic signed [31:0] o_taken_priority;
    logic signed [31:0] o_lowest_data;
    logic signed [31:0] o_lowest_priority;
    logic signed [31:0] o_highest_data;
    logic signed [31:0] o_highest_priority;
    logic [4:0]         o_entry_count;

    logic [31:0] shadow_data [DEPTH];
    t_pri        shadow_pri [DEPTH];
    int          shadow_count = 0;
    t_outcome    pending_outcomes [$];

    int mismatches  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;
    int hold_asked  = 0;
    int hold_given  = 0;
    int hold_left   = 0;

    sorted_double_ended_priority_queue_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_item_data        (i_item_data),
        .i_item_priority    (i_item_priority),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_taken_data       (o_taken_data),
        .o_taken_priority   (o_taken_priority),
        .o_lowest_data      (o_lowest_data),
        .o_lowest_priority  (o_lowest_priority),
        .o_highest_data     (o_highest_data),
        .o_highest_priority (o_highest_priority),
        .o_entry_count      (o_entry_count)
    );

    always begin
        i_clk = 1'b1;
        #CLOCK_HALF;
        i_clk = 1'b0;
        #CLOCK_HALF;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** sorted_double_ended_priority_queue_top: FAILED **");
            $finish;
        end
    end

    function automatic t_outcome queue_step(t_cmd cmd, logic [31:0] data, t_pri pri);
        t_outcome res;
        int       pos;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (shadow_count > 0 && shadow_pri[0] < pri &&
                        shadow_pri[shadow_count-1] <= pri) begin
                        pos = shadow_count;
                    end else begin
                        pos = 0;
                        while (pos < shadow_count && shadow_pri[pos] < pri)
                            pos++;
                    end
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_data[i] = shadow_data[i-1];
                        shadow_pri[i]  = shadow_pri[i-1];
                    end
                    shadow_data[pos] = data & DATA_MASK;
                    shadow_pri[pos]  = pri;
                    shadow_count++;
                end
            end
            CMD_EXT_LO: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.taken_data = shadow_data[0];
                    res.taken_pri  = shadow_pri[0];
                    for (int i = 1; i < shadow_count; i++) begin
                        shadow_data[i-1] = shadow_data[i];
                        shadow_pri[i-1]  = shadow_pri[i];
                    end
                    shadow_count--;
                end
            end
            CMD_EXT_HI: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.taken_data = shadow_data[shadow_count-1];
                    res.taken_pri  = shadow_pri[shadow_count-1];
                    shadow_count--;
                end
            end
            default: begin
            end
        endcase
        if (shadow_count > 0) begin
            res.low_data  = shadow_data[0];
            res.low_pri   = shadow_pri[0];
            res.high_data = shadow_data[shadow_count-1];
            res.high_pri  = shadow_pri[shadow_count-1];
        end
        res.count = 5'(shadow_count);
        return res;
    endfunction

    task automatic send_item(t_cmd cmd, logic [31:0] data, logic [31:0] pri);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_item_data     <= data;
        i_item_priority <= pri;
        do
            @(posedge i_clk);
        while (o_in_stall);
        pending_outcomes.push_back(queue_step(cmd, data, pri));
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected transfer, status", 32'(o_status), '0);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_taken_data !== want.taken_data)
                    report_mismatch("taken_data", o_taken_data, want.taken_data);
                if (o_taken_priority !== want.taken_pri)
                    report_mismatch("taken_priority", o_taken_priority, want.taken_pri);
                if (o_lowest_data !== want.low_data)
                    report_mismatch("lowest_data", o_lowest_data, want.low_data);
                if (o_lowest_priority !== want.low_pri)
                    report_mismatch("lowest_priority", o_lowest_priority, want.low_pri);
                if (o_highest_data !== want.high_data)
                    report_mismatch("highest_data", o_highest_data, want.high_data);
                if (o_highest_priority !== want.high_pri)
                    report_mismatch("highest_priority", o_highest_priority, want.high_pri);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", 32'(o_entry_count), 32'(want.count));
            end
        end
    end

    // A long hold-off is requested by bumping hold_asked and is timed here.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_asked != hold_given) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_given  <= hold_asked;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic [31:0] pick_priority();
        case ($urandom_range(9))
            0: return PRI_MIN;
            1: return PRI_MAX;
            2, 3, 4: return $urandom;
            default: return 32'($urandom_range(20)) - 32'd10;
        endcase
    endfunction

    function automatic t_cmd pick_command(int insert_pct);
        if ($urandom_range(99) < 3)
            return CMD_NONE;
        if ($urandom_range(99) < insert_pct)
            return CMD_INSERT;
        return $urandom_range(1) ? CMD_EXT_HI : CMD_EXT_LO;
    endfunction

    task automatic test_empty_store();
        send_item(CMD_EXT_LO, 32'h1234_5678, PRI_MAX);
        send_item(CMD_EXT_HI, 32'hFFFF_FFFF, PRI_MIN);
        send_item(CMD_NONE, 32'h0, 32'h0);
    endtask

    task automatic test_end_placement();
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h0);
        send_item(CMD_INSERT, 32'h8000_0000, PRI_MIN);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, PRI_MAX);
        send_item(CMD_INSERT, 32'h0000_0001, 32'h0);
        send_item(CMD_INSERT, 32'h0000_0002, PRI_MIN);
        send_item(CMD_INSERT, 32'h0000_0003, PRI_MAX);
        send_item(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_EXT_HI, 32'h0, 32'h0);
        send_item(CMD_EXT_LO, 32'h0, 32'h0);
    endtask

    task automatic test_full_store();
        while (shadow_count < DEPTH)
            send_item(CMD_INSERT, $urandom, pick_priority());
        send_item(CMD_INSERT, $urandom, pick_priority());
    endtask

    task automatic test_backpressure();
        hold_asked++;
        repeat (24)
            send_item(pick_command(60), $urandom, pick_priority());
    endtask

    task automatic test_steady_stream(int count);
        calm = 1'b1;
        for (int i = 0; i < count; i++)
            send_item(pick_command(50 + 25 * ((i / 40) % 2)), $urandom, pick_priority());
        calm = 1'b0;
    endtask

    task automatic test_random_mix(int count);
        int insert_pct;
        for (int i = 0; i < count; i++) begin
            case ((i / 48) % 3)
                0: insert_pct = 75;
                1: insert_pct = 50;
                default: insert_pct = 25;
            endcase
            send_item(pick_command(insert_pct), $urandom, pick_priority());
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_cmd           <= CMD_NONE;
        i_item_data     <= '0;
        i_item_priority <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_end_placement();
        test_full_store();
        test_backpressure();
        test_steady_stream(150);
        test_random_mix(600);

        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("** sorted_double_ended_priority_queue_top: PASSED **");
        else
            $display("** sorted_double_ended_priority_queue_top: FAILED **");
        $finish;
    end

endmodule

[sorted_double_ended_priority_queue_top.f]
hdl/sdpq_pkg.sv
hdl/sdpq_ram.sv
hdl/sorted_double_ended_priority_queue_top.sv
tb/sorted_double_ended_priority_queue_top_tb.sv
